[hdl/lbpu_pkg.sv]
`timescale 1ns / 1ps

package lbpu_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PTR_W   = 11;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] REFILL_SENTINEL = 32'h8000_0000;
    localparam logic [CNT_W-1:0]  FULL_BITS       = 6'd32;
    localparam logic [PTR_W-1:0]  BUFFER_WORDS_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WORDS = 1'b1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              word_valid;
        logic [DATA_W-1:0] word_out;
        logic [PTR_W-1:0]  word_index;
        logic              overflow;
        logic              past_end;
    } t_result;

    function automatic logic [DATA_W-1:0] f_low_mask(input logic [CNT_W-1:0] n);
        logic [DATA_W:0] t;
        t = ({{DATA_W{1'b0}}, 1'b1} << n) - {{DATA_W{1'b0}}, 1'b1};
        return t[DATA_W-1:0];
    endfunction

endpackage

[hdl/lsb_first_bit_packer_unpacker_unit.sv]
`timescale 1ns / 1ps
// channel  | valid        | flow control  | payload
// input    | i_in_valid   | o_in_stall    | i_command, i_value, i_bit_count
// output   | o_out_valid  | i_out_stall   | o_read_value, o_word_valid, o_word_out,
//          |              |               | o_word_index, o_overflow, o_past_end
// config   | i_cfg_valid  | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one transaction per cycle while not stalled; its result is registered
// the refill word is prefetched from the buffer memory at the next pointer every cycle,
// so the registered memory read never holds up a read
// synchronous reset clears pointer and accumulator, presets config; no memory clearing pass
// input stalls only while the output register and the skid entry are both full

module lsb_first_bit_packer_unpacker_unit
    import lbpu_pkg::*;
#(
    parameter int unsigned WORDS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [DATA_W-1:0]    i_value,
    input  logic [CNT_W-1:0]     i_bit_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_value,
    output logic                 o_word_valid,
    output logic [DATA_W-1:0]    o_word_out,
    output logic [PTR_W-1:0]     o_word_index,
    output logic                 o_overflow,
    output logic                 o_past_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PTR_W-1:0]     i_cfg_data
);

    localparam int unsigned CAP_MAX = (WORDS < 2047) ? WORDS : 2047;
    localparam int unsigned AW      = $clog2(CAP_MAX);
    localparam logic [PTR_W-1:0] CAP_LIM = PTR_W'(CAP_MAX);

    logic [DATA_W-1:0] r_mem [0:CAP_MAX-1];
    logic [DATA_W-1:0] r_rdata;

    logic              r_mode;
    logic [PTR_W-1:0]  r_bw;
    logic [DATA_W-1:0] r_acc;
    logic [CNT_W-1:0]  r_used;
    logic [PTR_W-1:0]  r_ptr;

    logic [DATA_W-1:0] n_acc;
    logic [CNT_W-1:0]  n_used;
    logic [PTR_W-1:0]  n_ptr;

    logic              w_accept;
    logic              w_stall;
    t_cmd              w_cmd;
    logic [CNT_W-1:0]  w_n;
    logic [PTR_W-1:0]  w_cap;
    logic              w_can;
    logic [PTR_W-1:0]  w_rd_ptr;
    logic              w_mem_we;
    logic [DATA_W-1:0] w_wdata;
    t_result           w_res;
    t_result           w_out;

    logic                  w_empty;
    logic [CNT_W-1:0]      wr_used0;
    logic [DATA_W-1:0]     wr_acc0;
    logic [2*DATA_W-1:0]   wr_wide;
    logic [CNT_W-1:0]      wr_sum;
    logic                  wr_full;
    logic [CNT_W-1:0]      rd_avail;
    logic [DATA_W-1:0]     rd_fill;
    logic                  rd_refill;
    logic [2*DATA_W-1:0]   rd_wide;
    logic [CNT_W-1:0]      rd_left;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_stall;
    assign w_accept    = i_in_valid && !w_stall;
    assign w_cmd       = t_cmd'(i_command);
    assign w_n         = (i_bit_count > FULL_BITS) ? FULL_BITS : i_bit_count;
    assign w_cap       = (r_bw < CAP_LIM) ? r_bw : CAP_LIM;
    assign w_can       = r_ptr < w_cap;

    // datapath for write: value lands above the used bits, upper half carries over
    assign w_empty  = r_used >= FULL_BITS;
    assign wr_used0 = w_empty ? '0 : r_used;
    assign wr_acc0  = w_empty ? '0 : r_acc;
    assign wr_wide  = {{DATA_W{1'b0}}, wr_acc0}
                    | ({{DATA_W{1'b0}}, i_value & f_low_mask(w_n)} << wr_used0);
    assign wr_sum   = wr_used0 + w_n;
    assign wr_full  = wr_sum >= FULL_BITS;

    // datapath for read: remaining bits below, refill word above them
    assign rd_avail  = w_empty ? '0 : FULL_BITS - r_used;
    assign rd_fill   = w_can ? r_rdata : REFILL_SENTINEL;
    assign rd_refill = w_empty || (w_n > rd_avail);
    assign rd_wide   = {{DATA_W{1'b0}}, r_acc & f_low_mask(rd_avail)}
                     | ({{DATA_W{1'b0}}, rd_fill} << rd_avail);
    assign rd_left   = w_n - rd_avail;

    always_comb begin
        n_acc    = r_acc;
        n_used   = r_used;
        n_ptr    = r_ptr;
        w_res    = '0;
        w_mem_we = 1'b0;
        w_wdata  = wr_wide[DATA_W-1:0];
        unique case (w_cmd)
            CMD_OPEN: begin
                n_ptr = '0;
                if (r_mode == MODE_READ) begin
                    n_used = FULL_BITS;
                end else begin
                    n_acc  = '0;
                    n_used = '0;
                end
            end
            CMD_WRITE: begin
                if (r_mode == MODE_WRITE) begin
                    if (wr_full) begin
                        w_res.word_valid = 1'b1;
                        w_res.word_out   = wr_wide[DATA_W-1:0];
                        w_res.word_index = r_ptr;
                        w_res.overflow   = !w_can;
                        w_mem_we         = w_can;
                        if (w_can) begin
                            n_ptr = r_ptr + PTR_W'(1);
                        end
                        n_acc  = wr_wide[2*DATA_W-1:DATA_W];
                        n_used = wr_sum - FULL_BITS;
                    end else begin
                        n_acc  = wr_wide[DATA_W-1:0];
                        n_used = wr_sum;
                    end
                end
            end
            CMD_READ: begin
                if (r_mode == MODE_READ) begin
                    if (rd_refill) begin
                        w_res.read_value = rd_wide[DATA_W-1:0] & f_low_mask(w_n);
                        w_res.past_end   = !w_can;
                        if (w_can) begin
                            n_ptr = r_ptr + PTR_W'(1);
                        end
                        n_acc  = rd_fill >> rd_left;
                        n_used = rd_left;
                    end else begin
                        w_res.read_value = r_acc & f_low_mask(w_n);
                        n_acc  = r_acc >> w_n;
                        n_used = r_used + w_n;
                    end
                end
            end
            CMD_CLOSE: begin
                if (r_mode == MODE_WRITE && r_used != '0) begin
                    w_res.word_valid = 1'b1;
                    w_res.word_out   = r_acc;
                    w_res.word_index = r_ptr;
                    w_res.overflow   = !w_can;
                    w_mem_we         = w_can;
                    w_wdata          = r_acc;
                    if (w_can) begin
                        n_ptr = r_ptr + PTR_W'(1);
                    end
                    n_acc  = '0;
                    n_used = '0;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    assign w_rd_ptr = w_accept ? n_ptr : r_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_READ;
            r_bw   <= BUFFER_WORDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_BUFFER_WORDS) begin
                r_bw <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_used <= FULL_BITS;
            r_ptr  <= '0;
        end else if (w_accept) begin
            r_acc  <= n_acc;
            r_used <= n_used;
            r_ptr  <= n_ptr;
        end
    end

    // write and prefetch never hit the same entry: a store always moves the pointer on
    always_ff @(posedge i_clk) begin
        if (w_accept && w_mem_we) begin
            r_mem[r_ptr[AW-1:0]] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_ptr[AW-1:0]];
    end

    lbpu_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (w_stall),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_read_value = w_out.read_value;
    assign o_word_valid = w_out.word_valid;
    assign o_word_out   = w_out.word_out;
    assign o_word_index = w_out.word_index;
    assign o_overflow   = w_out.overflow;
    assign o_past_end   = w_out.past_end;

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mem_we) |-> (r_ptr < w_cap))
        else $error("buffer store past capacity");

    a_store_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mem_we) |=> (r_ptr == $past(r_ptr) + PTR_W'(1)))
        else $error("pointer did not advance after store");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used <= FULL_BITS) && (r_ptr <= CAP_LIM))
        else $error("bit count or pointer out of range");

endmodule

[hdl/lbpu_out_skid.sv]
`timescale 1ns / 1ps

module lbpu_out_skid
    import lbpu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_accept;
    logic    w_out_free;

    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= i_data;
            end
        end else if (w_accept) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("transaction lost while output stalled");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid entry not drained");

endmodule

[bench/tb_lsb_first_bit_packer_unpacker_unit.sv]
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_unpacker_unit;
    import lbpu_pkg::*;

    localparam int unsigned WORDS_TB       = 1024;
    localparam int          PHASES         = 14;
    localparam int          PHASE_ITEMS    = 96;
    localparam int          LONG_HOLD      = 80;
    localparam int          WATCHDOG_LIMIT = 1000;

    class bitstream_scoreboard;
        logic              mode;
        logic [PTR_W-1:0]  buffer_words;
        logic [DATA_W-1:0] acc;
        int unsigned       used;
        int unsigned       ptr;
        logic [DATA_W-1:0] words [WORDS_TB];
        bit                written [WORDS_TB];
        t_result           step_out;
        t_result           results_due [$];
        int                errors;

        function new();
            mode         = MODE_READ;
            buffer_words = BUFFER_WORDS_RST;
            acc          = '0;
            used         = 32;
            ptr          = 0;
            errors       = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int unsigned capacity();
            return (buffer_words < WORDS_TB) ? buffer_words : WORDS_TB;
        endfunction

        function logic [DATA_W-1:0] mask_of(int unsigned n);
            return ~({DATA_W{1'b1}} << n);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [PTR_W-1:0] data);
            if (index == CFG_MODE) begin
                mode = data[0];
            end else begin
                buffer_words = data;
            end
        endfunction

        function void emit_word();
            step_out.word_valid = 1'b1;
            step_out.word_out   = acc;
            step_out.word_index = ptr[PTR_W-1:0];
            if (ptr < capacity()) begin
                words[ptr]   = acc;
                written[ptr] = 1'b1;
                ptr++;
            end else begin
                step_out.overflow = 1'b1;
            end
            acc  = '0;
            used = 0;
        endfunction

        function void refill_word();
            if (ptr < capacity()) begin
                acc = words[ptr];
                ptr++;
            end else begin
                acc = REFILL_SENTINEL;
                step_out.past_end = 1'b1;
            end
            used = 0;
        endfunction

        // a read must never pull in a buffer entry that was not written
        function bit read_hits_unwritten(logic [CNT_W-1:0] count);
            int unsigned n, p, u, s;
            if (mode != MODE_READ) return 1'b0;
            n = (count > 32) ? 32 : count;
            p = ptr;
            u = used;
            if (u >= 32) begin
                if (p < capacity() && !written[p]) return 1'b1;
                if (p < capacity()) p++;
                u = 0;
            end
            s = 32 - u;
            if (s > n) s = n;
            if (n > s && p < capacity() && !written[p]) return 1'b1;
            return 1'b0;
        endfunction

        function void note_item(t_cmd cmd, logic [DATA_W-1:0] value, logic [CNT_W-1:0] count);
            int unsigned       n, m, s;
            logic [DATA_W-1:0] v, w;
            n = (count > 32) ? 32 : count;
            v = value;
            step_out = '0;
            case (cmd)
                CMD_OPEN: begin
                    ptr = 0;
                    if (mode == MODE_READ) begin
                        used = 32;
                    end else begin
                        acc  = '0;
                        used = 0;
                    end
                end
                CMD_WRITE: begin
                    if (mode == MODE_WRITE) begin
                        if (used >= 32) begin
                            acc  = '0;
                            used = 0;
                        end
                        m = 32 - used;
                        if (m > n) m = n;
                        acc  = acc | ((v & mask_of(m)) << used);
                        used = used + m;
                        if (used == 32) emit_word();
                        v = v >> m;
                        n = n - m;
                        if (n > 0) begin
                            acc  = acc | (v & mask_of(n));
                            used = used + n;
                        end
                    end
                end
                CMD_READ: begin
                    if (mode == MODE_READ) begin
                        if (used >= 32) refill_word();
                        s = 32 - used;
                        if (s > n) s = n;
                        w    = acc & mask_of(s);
                        acc  = acc >> s;
                        used = used + s;
                        n    = n - s;
                        if (n > 0) begin
                            refill_word();
                            w    = w | ((acc & mask_of(n)) << s);
                            acc  = acc >> n;
                            used = used + n;
                        end
                        step_out.read_value = w;
                    end
                end
                CMD_CLOSE: begin
                    if (mode == MODE_WRITE && used > 0) emit_word();
                end
            endcase
            results_due.push_back(step_out);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("word_valid", want.word_valid, got.word_valid);
            compare_field("word_out",   want.word_out,   got.word_out);
            compare_field("word_index", want.word_index, got.word_index);
            compare_field("overflow",   want.overflow,   got.overflow);
            compare_field("past_end",   want.past_end,   got.past_end);
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_command   = CMD_OPEN;
    logic [DATA_W-1:0]    i_value     = '0;
    logic [CNT_W-1:0]     i_bit_count = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [DATA_W-1:0]    o_read_value;
    logic                 o_word_valid;
    logic [DATA_W-1:0]    o_word_out;
    logic [PTR_W-1:0]     o_word_index;
    logic                 o_overflow;
    logic                 o_past_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MODE;
    logic [PTR_W-1:0]     i_cfg_data  = '0;

    bitstream_scoreboard stream_sb = new();
    t_result             seen_result;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  long_hold_asks = 0;
    int                  long_hold_seen = 0;
    int                  hold_left      = 0;
    int                  quiet_cycles   = 0;

    lsb_first_bit_packer_unpacker_unit #(
        .WORDS(WORDS_TB)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_bit_count  (i_bit_count),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_word_valid (o_word_valid),
        .o_word_out   (o_word_out),
        .o_word_index (o_word_index),
        .o_overflow   (o_overflow),
        .o_past_end   (o_past_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // receiver side: random stalls plus a single long hold-off
    always @(negedge i_clk) begin
        if (long_hold_asks != long_hold_seen) begin
            long_hold_seen = long_hold_asks;
            hold_left      = LONG_HOLD;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_result.read_value = o_read_value;
                seen_result.word_valid = o_word_valid;
                seen_result.word_out   = o_word_out;
                seen_result.word_index = o_word_index;
                seen_result.overflow   = o_overflow;
                seen_result.past_end   = o_past_end;
                stream_sb.check_result(seen_result);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_lsb_first_bit_packer_unpacker_unit NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [PTR_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        stream_sb.set_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(input t_cmd cmd, input logic [DATA_W-1:0] value,
                             input logic [CNT_W-1:0] count);
        t_cmd sent;
        sent = cmd;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        if (sent == CMD_READ && stream_sb.read_hits_unwritten(count))
            sent = t_cmd'(stream_sb.written[0] ? CMD_OPEN : CMD_CLOSE);
        i_in_valid  = 1'b1;
        i_command   = sent;
        i_value     = value;
        i_bit_count = count;
        do @(posedge i_clk); while (o_in_stall);
        stream_sb.note_item(sent, value, count);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (stream_sb.results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [CNT_W-1:0] random_count();
        int r;
        r = $urandom_range(99);
        if (r < 10) return CNT_W'(0);
        if (r < 30) return CNT_W'(32);
        if (r < 45) return CNT_W'($urandom_range(8, 1));
        if (r < 92) return CNT_W'($urandom_range(32, 0));
        return CNT_W'($urandom_range(63, 33));
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return $urandom;
    endfunction

    function automatic logic [PTR_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 3;
            4:       return 5;
            5:       return 8;
            6:       return 17;
            7:       return 64;
            8:       return 1024;
            default: return 2047;
        endcase
    endfunction

    task automatic send_random_item(input bit write_phase);
        int   r;
        t_cmd cmd;
        r = $urandom_range(99);
        if (r < 3) begin
            cmd = CMD_OPEN;
        end else if (write_phase) begin
            cmd = t_cmd'((r < 9) ? CMD_CLOSE : (r < 12) ? CMD_READ : CMD_WRITE);
        end else begin
            cmd = t_cmd'((r < 5) ? CMD_WRITE : (r < 7) ? CMD_CLOSE : CMD_READ);
        end
        send_item(cmd, random_value(), random_count());
    endtask

    task automatic set_idling(input int sel);
        case (sel)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    initial begin
        logic [PTR_W-1:0] wr_cap;
        logic [PTR_W-1:0] rd_cap;
        bit               write_phase;
        wr_cap = BUFFER_WORDS_RST;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // packing: word boundaries, zero and oversized counts, flush, overflow
        write_reg(CFG_MODE, MODE_WRITE);
        write_reg(CFG_BUFFER_WORDS, 4);
        send_item(CMD_OPEN,  '0, 0);
        send_item(CMD_WRITE, 32'hFFFF_FFFF, 32);
        send_item(CMD_WRITE, 32'hFFFF_FFFF, 0);
        send_item(CMD_WRITE, 32'h0000_0001, 1);
        send_item(CMD_WRITE, 32'hAAAA_AAAA, 31);
        send_item(CMD_WRITE, 32'h1234_5678, 40);
        send_item(CMD_WRITE, 32'hFFFF_FFE5, 5);
        send_item(CMD_CLOSE, '0, 0);
        send_item(CMD_CLOSE, '0, 0);
        send_item(CMD_READ,  '1, 32);
        send_item(CMD_WRITE, 32'hDEAD_BEEF, 63);
        send_item(CMD_WRITE, '0, 32);
        wait_results_drained();

        // unpacking: empty refill on zero count, splits across words, past end
        write_reg(CFG_MODE, MODE_READ);
        send_item(CMD_OPEN,  '0, 0);
        send_item(CMD_READ,  '1, 0);
        send_item(CMD_READ,  '0, 32);
        send_item(CMD_READ,  '0, 1);
        send_item(CMD_READ,  '0, 31);
        send_item(CMD_READ,  '0, 7);
        send_item(CMD_READ,  '0, 63);
        send_item(CMD_READ,  '0, 20);
        send_item(CMD_READ,  '0, 20);
        send_item(CMD_WRITE, '1, 12);
        send_item(CMD_CLOSE, '0, 0);
        send_item(CMD_OPEN,  '0, 0);
        wait_results_drained();

        // full accumulator carried into write mode, then zero capacity
        write_reg(CFG_MODE, MODE_WRITE);
        send_item(CMD_WRITE, 32'h0000_01FF, 9);
        send_item(CMD_CLOSE, '0, 0);
        wait_results_drained();
        write_reg(CFG_BUFFER_WORDS, 0);
        send_item(CMD_OPEN,  '0, 0);
        send_item(CMD_WRITE, '1, 32);
        send_item(CMD_CLOSE, '0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_results_drained();
            write_phase = (ph % 2 == 0);
            set_idling((ph / 2) % 4);
            if (write_phase) begin
                wr_cap = pick_capacity();
                write_reg(CFG_MODE, MODE_WRITE);
                write_reg(CFG_BUFFER_WORDS, wr_cap);
            end else begin
                rd_cap = ($urandom_range(99) < 75) ? wr_cap : pick_capacity();
                write_reg(CFG_BUFFER_WORDS, rd_cap);
                write_reg(CFG_MODE, MODE_READ);
            end
            if ($urandom_range(99) < 85) send_item(CMD_OPEN, random_value(), random_count());
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 20) long_hold_asks = long_hold_asks + 1;
                if (ph == 4 && k == 48) wait_results_drained();
                send_random_item(write_phase);
            end
        end

        wait_results_drained();
        repeat (10) @(negedge i_clk);
        if (stream_sb.errors == 0 && stream_sb.results_due.size() == 0) begin
            $display("tb_lsb_first_bit_packer_unpacker_unit OK");
        end else begin
            $display("tb_lsb_first_bit_packer_unpacker_unit NOT OK");
        end
        $finish;
    end

endmodule
